/* rtl/mbrtu_pkg.sv */
// Package for the Modbus RTU reply checker.
// Holds frame descriptor and config types, status and function codes, the CRC step.
// No dependencies.
package mbrtu_pkg;

	localparam logic [7:0]  FC_READ  = 8'h03;
	localparam logic [7:0]  FC_WRITE = 8'h10;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_FUNC  = 3'd2;
	localparam logic [2:0] ST_COUNT = 3'd3;
	localparam logic [2:0] ST_CRC   = 3'd4;
	localparam logic [2:0] ST_LEN   = 3'd5;

	localparam logic [2:0] CFG_SLAVE_ADDRESS  = 3'd0;
	localparam logic [2:0] CFG_EXPECT_WRITE   = 3'd1;
	localparam logic [2:0] CFG_START_REGISTER = 3'd2;
	localparam logic [2:0] CFG_REGISTER_COUNT = 3'd3;
	localparam logic [2:0] CFG_READ_MASK      = 3'd4;

	typedef struct packed {
		logic [7:0] slave_address;
		logic       expect_write_reply;
		logic [5:0] start_register;
		logic [5:0] register_count;
	} cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic       good_read;
	} desc_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

/* rtl/mbrtu_front.sv */
// Front end: takes reply bytes, runs the checks and the CRC, fills the word buffer.
// Emits one frame descriptor per frame end. Depends on mbrtu_pkg.
module mbrtu_front import mbrtu_pkg::*; #(
	parameter int MAX_REGS  = 32,
	parameter int MAX_FRAME = 255,
	parameter int AW        = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          frame_end,
	input  cfg_t          cfg,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [15:0]   wr_data,
	output logic          push,
	output desc_t         desc
);

	logic [15:0] crc_q;
	logic [7:0]  pos_q;
	logic [2:0]  err_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [7:0]  whigh_q;

	logic        rd;
	logic        at_limit;
	logic [7:0]  fc_exp;
	logic [2:0]  err_now;
	logic [2:0]  err_nx;
	logic [7:0]  pos_nx;
	logic [15:0] crc_nx;
	logic [7:0]  off;
	logic [6:0]  w;
	logic        in_word;
	logic [2:0]  st;

	always_comb begin
		rd       = !cfg.expect_write_reply;
		fc_exp   = rd ? FC_READ : FC_WRITE;
		at_limit = pos_q >= 8'(MAX_FRAME);
		err_now  = ST_OK;
		if (at_limit)
			err_now = ST_LEN;
		else if (pos_q == 8'd0 && data_byte != cfg.slave_address)
			err_now = ST_ADDR;
		else if (pos_q == 8'd1 && data_byte != fc_exp)
			err_now = ST_FUNC;
		else if (rd && pos_q == 8'd2 &&
				({1'b0, cfg.register_count} > 7'(MAX_REGS) ||
				data_byte != {1'b0, cfg.register_count, 1'b0}))
			err_now = ST_COUNT;
		err_nx  = (err_q != ST_OK) ? err_q : err_now;
		pos_nx  = at_limit ? pos_q : pos_q + 8'd1;
		crc_nx  = (pos_q >= 8'd2) ? crc_feed(crc_q, held0_q) : crc_q;
		off     = pos_q - 8'd3;
		w       = off[7:1];
		in_word = rd && !at_limit && pos_q >= 8'd3 &&
			w < {1'b0, cfg.register_count} && w < 7'(MAX_REGS);
		wr_en   = accept && in_word && off[0];
		wr_addr = w[AW-1:0];
		wr_data = {whigh_q, data_byte};

		if (err_nx != ST_OK)
			st = err_nx;
		else if (rd ? ({1'b0, pos_nx} != 9'd5 + {2'b00, cfg.register_count, 1'b0})
				: (pos_nx < 8'd4))
			st = ST_LEN;
		else if (held1_q != crc_nx[7:0] || data_byte != crc_nx[15:8])
			st = ST_CRC;
		else
			st = ST_OK;
		push           = accept && frame_end;
		desc.status    = st;
		desc.good_read = (st == ST_OK) && rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			pos_q   <= '0;
			err_q   <= ST_OK;
			held0_q <= '0;
			held1_q <= '0;
			whigh_q <= '0;
		end else if (push) begin
			crc_q   <= CRC_INIT;
			pos_q   <= '0;
			err_q   <= ST_OK;
			held0_q <= '0;
			held1_q <= '0;
			whigh_q <= '0;
		end else if (accept) begin
			crc_q   <= crc_nx;
			pos_q   <= pos_nx;
			err_q   <= err_nx;
			held0_q <= held1_q;
			held1_q <= data_byte;
			if (in_word && !off[0])
				whigh_q <= data_byte;
		end
	end

endmodule

/* rtl/mbrtu_queue.sv */
// Two-entry queue of frame descriptors between front and back end.
// Depends on mbrtu_pkg.
module mbrtu_queue import mbrtu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  not_empty,
	output logic  full,
	output desc_t head
);

	desc_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign not_empty = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* rtl/mbrtu_back.sv */
// Back end: holds the word buffer, drains enabled words of a good read reply,
// then sends the frame status beat. Depends on mbrtu_pkg.
module mbrtu_back import mbrtu_pkg::*; #(
	parameter int MAX_REGS  = 32,
	parameter int MASK_BITS = 64,
	parameter int AW        = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic [MASK_BITS-1:0] mask,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [15:0]          wr_data,
	input  logic                 desc_valid,
	input  desc_t                desc,
	output logic                 pop,
	output logic                 hold_clr,
	output logic                 strobe,
	output logic                 item_kind,
	output logic [5:0]           reg_index,
	output logic [15:0]          reg_value,
	output logic [2:0]           status,
	output logic                 last
);

	localparam int CW = $clog2(MAX_REGS + 1);
	localparam int MW = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WORDS = 2'd1;
	localparam logic [1:0] S_FIN   = 2'd2;

	logic [15:0]   mem [MAX_REGS];
	logic [1:0]    state_q;
	desc_t         cur_q;
	logic [CW-1:0] kc_q;
	logic [CW-1:0] lim;
	logic [6:0]    idx;
	logic          en;
	logic          issue;
	logic          emit_st;

	logic          v_s1;
	logic          en_s1;
	logic [5:0]    idx_s1;
	logic [15:0]   rdata_s1;

	logic          strobe_q;
	logic          kind_q;
	logic [5:0]    index_q;
	logic [15:0]   value_q;
	logic [2:0]    status_q;
	logic          last_q;

	always_comb begin
		if ({1'b0, cfg.register_count} > 7'(MAX_REGS))
			lim = CW'(MAX_REGS);
		else
			lim = CW'(cfg.register_count);
		idx      = {1'b0, cfg.start_register} + 7'(kc_q);
		en       = (idx < 7'(MASK_BITS)) && mask[idx[MW-1:0]];
		issue    = state_q == S_WORDS;
		emit_st  = (state_q == S_FIN) && !v_s1;
		pop      = (state_q == S_IDLE) && desc_valid;
		hold_clr = emit_st && cur_q.good_read;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (issue)
			rdata_s1 <= mem[kc_q[AW-1:0]];
		idx_s1 <= idx[5:0];
		en_s1  <= en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			kc_q    <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (desc_valid) begin
						cur_q   <= desc;
						kc_q    <= '0;
						state_q <= (desc.good_read && lim != '0) ? S_WORDS : S_FIN;
					end
				end
				S_WORDS: begin
					kc_q <= kc_q + CW'(1);
					if (kc_q == lim - CW'(1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (!v_s1)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= (v_s1 && en_s1) || emit_st;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kind_q   <= 1'b0;
			index_q  <= idx_s1;
			value_q  <= rdata_s1;
			status_q <= ST_OK;
			last_q   <= 1'b0;
		end else begin
			kind_q   <= 1'b1;
			index_q  <= '0;
			value_q  <= '0;
			status_q <= cur_q.status;
			last_q   <= 1'b1;
		end
	end

	assign strobe    = strobe_q;
	assign item_kind = kind_q;
	assign reg_index = index_q;
	assign reg_value = value_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

/* rtl/modbus_rtu_reply_checker_core.sv */
// Top level of the Modbus RTU reply checker: config registers, front end, queue, back end.
// Depends on mbrtu_pkg, mbrtu_front, mbrtu_queue, mbrtu_back.
//
// channel   direction  handshake                 payload
// byte in   in         start && !busy            data_byte, frame_end
// result    out        strobe (one cycle)        item_kind, reg_index, reg_value, status, last
// config    in         cfg_valid && cfg_ready    cfg_index, cfg_data
//
// One byte per cycle is taken while busy is low; the checks and a CRC step run in that cycle.
// With the back end idle, the status beat of a frame passes the descriptor queue, the
// back-end state register and the output register after its last byte; for a good read
// reply the enabled word beats come first, one word read per cycle, then the status beat.
// busy stays high from the end of a good read reply until its status beat, and while
// the two-entry descriptor queue is full. Results cannot be stalled.
// Reset clears all control state at once; the word buffer needs no clearing.
module modbus_rtu_reply_checker_core import mbrtu_pkg::*; #(
	parameter int MAX_REGS  = 32,
	parameter int MASK_BITS = 64,
	parameter int MAX_FRAME = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        strobe,
	output logic        item_kind,
	output logic [5:0]  reg_index,
	output logic [15:0] reg_value,
	output logic [2:0]  status,
	output logic        last
);

	localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

	cfg_t                 cfg_q;
	logic [MASK_BITS-1:0] mask_q;
	logic                 hold_q;

	logic                 accept;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [15:0]          wr_data;
	logic                 push;
	desc_t                push_desc;
	logic                 pop;
	logic                 q_valid;
	logic                 q_full;
	desc_t                q_head;
	logic                 hold_clr;

	assign cfg_ready = 1'b1;
	assign busy      = q_full || hold_q;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address      <= 8'd1;
			cfg_q.expect_write_reply <= 1'b0;
			cfg_q.start_register     <= '0;
			cfg_q.register_count     <= '0;
			mask_q                   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLAVE_ADDRESS:  cfg_q.slave_address      <= cfg_data[7:0];
				CFG_EXPECT_WRITE:   cfg_q.expect_write_reply <= cfg_data[0];
				CFG_START_REGISTER: cfg_q.start_register     <= cfg_data[5:0];
				CFG_REGISTER_COUNT: cfg_q.register_count     <= cfg_data[5:0];
				CFG_READ_MASK:      mask_q                   <= cfg_data[MASK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_q <= 1'b0;
		else if (push && push_desc.good_read)
			hold_q <= 1'b1;
		else if (hold_clr)
			hold_q <= 1'b0;
	end

	mbrtu_front #(
		.MAX_REGS (MAX_REGS),
		.MAX_FRAME(MAX_FRAME),
		.AW       (AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data_byte(data_byte),
		.frame_end(frame_end),
		.cfg      (cfg_q),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.push     (push),
		.desc     (push_desc)
	);

	mbrtu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_desc(push_desc),
		.pop      (pop),
		.not_empty(q_valid),
		.full     (q_full),
		.head     (q_head)
	);

	mbrtu_back #(
		.MAX_REGS (MAX_REGS),
		.MASK_BITS(MASK_BITS),
		.AW       (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mask      (mask_q),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.desc_valid(q_valid),
		.desc      (q_head),
		.pop       (pop),
		.hold_clr  (hold_clr),
		.strobe    (strobe),
		.item_kind (item_kind),
		.reg_index (reg_index),
		.reg_value (reg_value),
		.status    (status),
		.last      (last)
	);

endmodule

/* rtl/mbrtu_checker.sv */
// Port-level checks for the Modbus RTU reply checker, bound to the top level.
// Depends on modbus_rtu_reply_checker_core.
module mbrtu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        strobe,
	input logic        item_kind,
	input logic [5:0]  reg_index,
	input logic [15:0] reg_value,
	input logic [2:0]  status,
	input logic        last
);

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> item_kind)
		else $error("last beat is not a status beat");

	a_word_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !item_kind |-> status == 3'd0 && !last)
		else $error("word beat carries status or last");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && item_kind |-> reg_index == 6'd0 && reg_value == 16'd0 &&
			status <= 3'd5)
		else $error("bad status beat");

	a_word_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !item_kind |-> busy && $past(busy))
		else $error("word beat without buffer hold");

endmodule

bind modbus_rtu_reply_checker_core mbrtu_checker u_mbrtu_checker (.*);
